// ----- rtl/iba_pkg.sv -----
// ----------------------------------------------------------------------------
// iba_pkg
// Shared types and constants of the inode block allocator.
// ----------------------------------------------------------------------------
package iba_pkg;

  localparam int NumBlocks     = 256;
  localparam int BlkW          = 8;
  localparam int FileSlots     = 16;
  localparam int SlotW         = 4;
  localparam int MaxFileBlocks = 63;
  localparam int BlockBytes    = 128;
  localparam int BlockShift    = 7;

  localparam logic [1:0] ACT_FORMAT = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_APPEND = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NO_FILE  = 2'd2;
  localparam logic [1:0] ST_TOO_BIG  = 2'd3;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ALLOC = 2'd1;
  localparam logic [1:0] EV_FREE  = 2'd2;

  typedef struct packed {
    logic       latch;
    logic       decide;
    logic       check;
    logic       cnt_clr;
    logic       cnt_ld_held;
    logic       fmt_wr;
    logic       rel_push;
    logic       alc_pop;
    logic       emit_none;
    logic [1:0] emit_st;
    logic       last;
    logic       fin_rel;
    logic       fin_alloc;
  } iba_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       in_use;
    logic       too_big;
    logic       short_space;
    logic       grow;
    logic       rel_last;
    logic       alc_last;
    logic       fmt_done;
    logic       free_zero;
    logic       out_free;
  } iba_sts_t;

endpackage

// ----- rtl/inode_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// inode_block_allocator_unit
// Disk block allocator with a FIFO free list and per-slot inodes.
// ----------------------------------------------------------------------------
// Input channel in_*: one command transaction (format, load, delete, append).
// Output channel out_*: one transaction per block allocated or freed, or one
// status-only transaction when no block moves; tlast marks the final one.
// cfg_we/cfg_wdata set the disk size used by the next format.
// Sequence: a command is accepted, decoded and checked (format skips the
// check), then each block moved takes a RAM read and a result; a load passes
// one more check state before its allocation. Format sweeps the free ring at
// one block per cycle. The ring, direct and indexed tables each sit in a RAM
// with one registered read port, which is why each block needs a read state
// before its result.
// Reset empties the free list and all slots; no format pass runs by itself.
// One command is in flight at a time; a new one is taken while the final
// result of the previous command still waits in the output register.
// A stalled receiver holds the sequencer at its next result.
// ----------------------------------------------------------------------------
module inode_block_allocator_unit
  import iba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // action[1:0], file_id[5:2], append_length[18:6]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status, block_number, block_event, block_role,
                                  // size_in_bytes, free_block_count
  output logic        out_tlast
);

  iba_cmd_t cmd;
  iba_sts_t sts;
  logic     idle;

  assign in_tready = idle;

  iba_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && idle),
    .sts     (sts),
    .idle    (idle),
    .cmd     (cmd)
  );

  iba_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- rtl/iba_ram.sv -----
// ----------------------------------------------------------------------------
// iba_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module iba_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/iba_ctrl.sv -----
// ----------------------------------------------------------------------------
// iba_ctrl
// Sequencer: steps one command through format, release and allocation.
// ----------------------------------------------------------------------------
module iba_ctrl
  import iba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  iba_sts_t sts,
  output logic     idle,
  output iba_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_CHECK, S_FMT, S_REL_RD, S_REL_EM,
    S_LD_CHK, S_ALC_RD, S_ALC_EM, S_ONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] one_st_r, one_st_nxt;
  logic       one_fin_r, one_fin_nxt;

  assign idle = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    one_st_nxt  = one_st_r;
    one_fin_nxt = one_fin_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt = (sts.action == ACT_FORMAT) ? S_FMT : S_CHECK;
      end
      S_CHECK: begin
        cmd.check   = 1'b1;
        one_fin_nxt = 1'b0;
        case (sts.action)
          ACT_LOAD: begin
            cmd.cnt_clr = 1'b1;
            state_nxt = sts.in_use ? S_REL_RD : S_LD_CHK;
          end
          ACT_DELETE: begin
            cmd.cnt_clr = 1'b1;
            if (sts.in_use) begin
              state_nxt = S_REL_RD;
            end else begin
              one_st_nxt = ST_NO_FILE;
              state_nxt  = S_ONE;
            end
          end
          default: begin
            if (!sts.in_use) begin
              one_st_nxt = ST_NO_FILE;
              state_nxt  = S_ONE;
            end else if (sts.too_big) begin
              one_st_nxt = ST_TOO_BIG;
              state_nxt  = S_ONE;
            end else if (sts.short_space) begin
              one_st_nxt = ST_NO_SPACE;
              state_nxt  = S_ONE;
            end else if (sts.grow) begin
              cmd.cnt_ld_held = 1'b1;
              state_nxt = S_ALC_RD;
            end else begin
              one_st_nxt  = ST_OK;
              one_fin_nxt = 1'b1;
              state_nxt   = S_ONE;
            end
          end
        endcase
      end
      S_FMT: begin
        one_fin_nxt = 1'b0;
        if (sts.fmt_done) begin
          one_st_nxt = ST_OK;
          state_nxt  = S_ONE;
        end else begin
          cmd.fmt_wr = 1'b1;
        end
      end
      S_REL_RD: state_nxt = S_REL_EM;
      S_REL_EM: begin
        if (sts.out_free) begin
          cmd.rel_push = 1'b1;
          cmd.last     = sts.rel_last && (sts.action == ACT_DELETE);
          cmd.fin_rel  = sts.rel_last;
          if (!sts.rel_last) begin
            state_nxt = S_REL_RD;
          end else if (sts.action == ACT_LOAD) begin
            state_nxt = S_LD_CHK;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LD_CHK: begin
        cmd.cnt_clr = 1'b1;
        one_fin_nxt = 1'b0;
        if (sts.free_zero) begin
          one_st_nxt = ST_NO_SPACE;
          state_nxt  = S_ONE;
        end else begin
          state_nxt = S_ALC_RD;
        end
      end
      S_ALC_RD: state_nxt = S_ALC_EM;
      S_ALC_EM: begin
        if (sts.out_free) begin
          cmd.alc_pop   = 1'b1;
          cmd.last      = sts.alc_last;
          cmd.fin_alloc = sts.alc_last;
          state_nxt     = sts.alc_last ? S_IDLE : S_ALC_RD;
        end
      end
      S_ONE: begin
        if (sts.out_free) begin
          cmd.emit_none = 1'b1;
          cmd.emit_st   = one_st_r;
          cmd.last      = 1'b1;
          cmd.fin_alloc = one_fin_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      one_st_r  <= ST_OK;
      one_fin_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      one_st_r  <= one_st_nxt;
      one_fin_r <= one_fin_nxt;
    end
  end

endmodule

// ----- rtl/iba_dp.sv -----
// ----------------------------------------------------------------------------
// iba_dp
// Datapath: free ring, inode tables, size math and the result register.
// ----------------------------------------------------------------------------
module iba_dp
  import iba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic [23:0] in_tdata,
  input  iba_cmd_t    cmd,
  output iba_sts_t    sts,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [39:0] out_tdata,
  output logic        out_tlast
);

  logic [8:0]       disk_r;
  logic [1:0]       action_r;
  logic [SlotW-1:0] fid_r;
  logic [12:0]      alen_r;
  logic [13:0]      total_r;
  logic [7:0]       need_r;
  logic [13:0]      size_r;
  logic [8:0]       cnt_r;
  logic [BlkW-1:0]  head_r, tail_r;
  logic [8:0]       free_r;
  logic [FileSlots-1:0] in_use_r;
  logic [5:0]       held_r [FileSlots];
  logic [12:0]      data_r [FileSlots];
  logic [BlkW-1:0]  iloc_r [FileSlots];

  logic             ov_r;
  logic [1:0]       o_st_r, o_ev_r;
  logic [BlkW-1:0]  o_blk_r;
  logic             o_role_r, o_last_r;
  logic [8:0]       o_free_r;
  logic [13:0]      o_size_r;

  logic [8:0]       fmt_n;
  logic [5:0]       held;
  logic             in_use;
  logic [13:0]      total_c;
  logic [14:0]      round_c;
  logic [7:0]       raw_c, need_c;
  logic [13:0]      size_c;
  logic [BlkW-1:0]  ring_rd, dir_rd, idx_rd, rel_blk;
  logic             ring_we, dir_we, idx_we;
  logic [5:0]       dir_addr, idx_off;
  logic [9:0]       idx_addr;
  logic             is_idx;
  logic             emit;
  logic [8:0]       free_nxt;

  assign fmt_n   = (disk_r > 9'(NumBlocks)) ? 9'(NumBlocks) : disk_r;
  assign held    = held_r[fid_r];
  assign in_use  = in_use_r[fid_r];
  assign total_c = 14'(data_r[fid_r]);

  assign round_c = 15'(total_c + 14'(alen_r)) + 15'(BlockBytes - 1);
  assign raw_c   = 8'(round_c >> BlockShift) + 8'd1;
  assign need_c  = (action_r == ACT_LOAD) ? 8'd1 : ((raw_c > 8'd3) ? raw_c + 8'd1 : raw_c);

  always_comb begin
    size_c = '0;
    case (action_r)
      ACT_LOAD: size_c = (in_use || free_r != '0) ? 14'(BlockBytes) : '0;
      ACT_APPEND: begin
        if (in_use) begin
          if (sts.too_big || sts.short_space) begin
            size_c = 14'(BlockBytes) + 14'(data_r[fid_r])
                   + ((held > 6'd3) ? 14'(BlockBytes) : 14'd0);
          end else begin
            size_c = 14'(BlockBytes) + total_r
                   + ((need_r > 8'd3) ? 14'(BlockBytes) : 14'd0);
          end
        end
      end
      default: size_c = '0;
    endcase
  end

  assign sts.action      = action_r;
  assign sts.in_use      = in_use;
  assign sts.too_big     = need_r > 8'(MaxFileBlocks);
  assign sts.short_space = (need_r > {2'b0, held})
                        && (free_r < ({1'b0, need_r} - {3'b0, held}));
  assign sts.grow        = need_r > {2'b0, held};
  assign sts.rel_last    = cnt_r == ({3'b0, held} - 9'd1);
  assign sts.alc_last    = (cnt_r + 9'd1) == {1'b0, need_r};
  assign sts.fmt_done    = cnt_r == fmt_n;
  assign sts.free_zero   = free_r == '0;
  assign sts.out_free    = !ov_r || out_tready;

  assign is_idx   = cnt_r[5:0] == 6'd3;
  assign dir_addr = {fid_r, cnt_r[1:0]};
  assign idx_off  = cnt_r[5:0] - 6'd4;
  assign idx_addr = {fid_r, idx_off};

  assign ring_we = cmd.fmt_wr || cmd.rel_push;
  assign dir_we  = cmd.alc_pop && (cnt_r < 9'd3);
  assign idx_we  = cmd.alc_pop && (cnt_r > 9'd3);

  always_comb begin
    if (cnt_r < 9'd3) begin
      rel_blk = dir_rd;
    end else if (is_idx) begin
      rel_blk = iloc_r[fid_r];
    end else begin
      rel_blk = idx_rd;
    end
  end

  iba_ram #(.Width(BlkW), .Depth(NumBlocks)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (cmd.fmt_wr ? cnt_r[BlkW-1:0] : tail_r),
    .wdata (cmd.fmt_wr ? cnt_r[BlkW-1:0] : rel_blk),
    .raddr (head_r),
    .rdata (ring_rd)
  );

  iba_ram #(.Width(BlkW), .Depth(64)) u_direct (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_addr),
    .wdata (ring_rd),
    .raddr (dir_addr),
    .rdata (dir_rd)
  );

  iba_ram #(.Width(BlkW), .Depth(1024)) u_indexed (
    .clk   (clk),
    .we    (idx_we),
    .waddr (idx_addr),
    .wdata (ring_rd),
    .raddr (idx_addr),
    .rdata (idx_rd)
  );

  assign emit = cmd.rel_push || cmd.alc_pop || cmd.emit_none;

  always_comb begin
    free_nxt = free_r;
    if (cmd.rel_push) begin
      free_nxt = free_r + 9'd1;
    end else if (cmd.alc_pop) begin
      free_nxt = free_r - 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_r   <= 9'(NumBlocks);
      head_r   <= '0;
      tail_r   <= '0;
      free_r   <= '0;
      in_use_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        disk_r <= cfg_wdata;
      end
      if (cmd.decide && action_r == ACT_FORMAT) begin
        head_r   <= '0;
        tail_r   <= fmt_n[BlkW-1:0];
        free_r   <= fmt_n;
        in_use_r <= '0;
      end else begin
        free_r <= free_nxt;
        if (cmd.rel_push) begin
          tail_r <= tail_r + 8'd1;
        end
        if (cmd.alc_pop) begin
          head_r <= head_r + 8'd1;
        end
        if (cmd.fin_rel) begin
          in_use_r[fid_r] <= 1'b0;
        end
        if (cmd.fin_alloc) begin
          in_use_r[fid_r] <= 1'b1;
        end
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      action_r <= in_tdata[1:0];
      fid_r    <= in_tdata[5:2];
      alen_r   <= in_tdata[18:6];
    end
    if (cmd.decide) begin
      total_r <= total_c + 14'(alen_r);
      need_r  <= need_c;
      size_r  <= '0;
    end
    if (cmd.check) begin
      size_r <= size_c;
    end
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_ld_held) begin
      cnt_r <= {3'b0, held};
    end else if (cmd.fmt_wr || cmd.rel_push || cmd.alc_pop) begin
      cnt_r <= cnt_r + 9'd1;
    end
    if (cmd.alc_pop) begin
      held_r[fid_r] <= cnt_r[5:0] + 6'd1;
      if (is_idx) begin
        iloc_r[fid_r] <= ring_rd;
      end
    end
    if (cmd.fin_alloc) begin
      data_r[fid_r] <= (action_r == ACT_LOAD) ? 13'd0 : total_r[12:0];
    end
    if (emit) begin
      o_last_r <= cmd.last;
      o_free_r <= free_nxt;
      o_size_r <= size_r;
      if (cmd.rel_push) begin
        o_st_r   <= ST_OK;
        o_ev_r   <= EV_FREE;
        o_blk_r  <= rel_blk;
        o_role_r <= is_idx;
      end else if (cmd.alc_pop) begin
        o_st_r   <= ST_OK;
        o_ev_r   <= EV_ALLOC;
        o_blk_r  <= ring_rd;
        o_role_r <= is_idx;
      end else begin
        o_st_r   <= cmd.emit_st;
        o_ev_r   <= EV_NONE;
        o_blk_r  <= '0;
        o_role_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {4'b0, o_free_r, o_size_r, o_role_r, o_ev_r, o_blk_r, o_st_r};

endmodule

// ----- tb/iba_checker.sv -----
// ----------------------------------------------------------------------------
// iba_checker
// Watches the command and result streams of the inode block allocator,
// predicts every block allocation and release, and counts mismatches.
// ----------------------------------------------------------------------------
module iba_checker
  import iba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  blk;
    logic [1:0]  event_kind;
    logic        role;
    logic [13:0] size;
    logic [8:0]  free_cnt;
    logic        last;
  } block_result_t;

  block_result_t expected_results[$];
  block_result_t step_results[$];

  logic [8:0]  disk_size;
  logic [7:0]  ring [NumBlocks];
  logic [7:0]  ring_head, ring_tail;
  int          ring_count;
  logic        in_use [FileSlots];
  logic [7:0]  directs [FileSlots][3];
  logic [7:0]  index_blk [FileSlots];
  logic [7:0]  indexed [FileSlots][64];
  int          held_cnt [FileSlots];
  int          data_len [FileSlots];

  assign pending = expected_results.size();

  function automatic void add_result(logic [1:0] st, logic [7:0] b, logic [1:0] ev,
                                     logic role);
    block_result_t r;
    r = '0;
    r.status = st;
    r.blk = b;
    r.event_kind = ev;
    r.role = role;
    r.free_cnt = ring_count[8:0];
    step_results.insert(step_results.size(), r);
  endfunction

  function automatic void push_block(logic [7:0] b);
    if (ring_count < NumBlocks) begin
      ring[ring_tail] = b;
      ring_tail++;
      ring_count++;
    end
  endfunction

  function automatic logic [7:0] pop_block();
    logic [7:0] b;
    b = ring[ring_head];
    ring_head++;
    ring_count--;
    return b;
  endfunction

  function automatic void release_slot(int s);
    int nd;
    nd = held_cnt[s] < 3 ? held_cnt[s] : 3;
    for (int i = 0; i < nd; i++) begin
      push_block(directs[s][i]);
      add_result(ST_OK, directs[s][i], EV_FREE, 1'b0);
    end
    if (held_cnt[s] > 3) begin
      push_block(index_blk[s]);
      add_result(ST_OK, index_blk[s], EV_FREE, 1'b1);
      for (int i = 0; i + 4 < held_cnt[s]; i++) begin
        push_block(indexed[s][i]);
        add_result(ST_OK, indexed[s][i], EV_FREE, 1'b0);
      end
    end
    in_use[s] = 1'b0;
  endfunction

  function automatic void predict_command(logic [23:0] cmd);
    logic [1:0] act;
    int s, alen, sz, total, need, held, n;
    logic [7:0] b;
    act = cmd[1:0];
    s = int'(cmd[5:2]);
    alen = int'(cmd[18:6]);
    sz = 0;
    step_results.delete();
    if (act == ACT_FORMAT) begin
      n = disk_size > NumBlocks ? NumBlocks : int'(disk_size);
      ring_head = '0;
      ring_tail = '0;
      ring_count = 0;
      for (int i = 0; i < n; i++) push_block(i[7:0]);
      for (int i = 0; i < FileSlots; i++) in_use[i] = 1'b0;
      add_result(ST_OK, 8'd0, EV_NONE, 1'b0);
    end else if (act == ACT_LOAD) begin
      if (in_use[s]) release_slot(s);
      if (ring_count == 0) begin
        add_result(ST_NO_SPACE, 8'd0, EV_NONE, 1'b0);
      end else begin
        b = pop_block();
        in_use[s] = 1'b1;
        directs[s][0] = b;
        held_cnt[s] = 1;
        data_len[s] = 0;
        add_result(ST_OK, b, EV_ALLOC, 1'b0);
      end
    end else if (act == ACT_DELETE) begin
      if (in_use[s]) release_slot(s);
      else add_result(ST_NO_FILE, 8'd0, EV_NONE, 1'b0);
    end else begin
      if (!in_use[s]) begin
        add_result(ST_NO_FILE, 8'd0, EV_NONE, 1'b0);
      end else begin
        total = data_len[s] + alen;
        need = 1 + (total + BlockBytes - 1) / BlockBytes;
        held = held_cnt[s];
        if (need > 3) need++;
        if (need > MaxFileBlocks) begin
          add_result(ST_TOO_BIG, 8'd0, EV_NONE, 1'b0);
        end else if (need > held && ring_count < need - held) begin
          add_result(ST_NO_SPACE, 8'd0, EV_NONE, 1'b0);
        end else begin
          while (held < need) begin
            b = pop_block();
            if (held < 3) directs[s][held] = b;
            else if (held == 3) index_blk[s] = b;
            else indexed[s][held - 4] = b;
            add_result(ST_OK, b, EV_ALLOC, held == 3);
            held++;
          end
          held_cnt[s] = held;
          data_len[s] = total & 13'h1fff;
          if (step_results.size() == 0) add_result(ST_OK, 8'd0, EV_NONE, 1'b0);
        end
      end
    end
    if (act != ACT_FORMAT && act != ACT_DELETE && in_use[s])
      sz = BlockBytes + data_len[s] + (held_cnt[s] > 3 ? BlockBytes : 0);
    foreach (step_results[i]) begin
      step_results[i].size = sz[13:0];
      step_results[i].last = (i == step_results.size() - 1);
      expected_results.insert(expected_results.size(), step_results[i]);
    end
  endfunction

  always @(posedge clk) begin
    block_result_t got, want;
    if (!rst_n) begin
      disk_size <= 9'd256;
      ring_head = '0;
      ring_tail = '0;
      ring_count = 0;
      for (int i = 0; i < FileSlots; i++) in_use[i] = 1'b0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we) disk_size <= cfg_wdata;
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.blk = out_tdata[9:2];
        got.event_kind = out_tdata[11:10];
        got.role = out_tdata[12];
        got.size = out_tdata[26:13];
        got.free_cnt = out_tdata[35:27];
        got.last = out_tlast;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: st %0d/%0d blk %0d/%0d ev %0d/%0d role %0d/%0d size %0d/%0d free %0d/%0d last %0d/%0d",
                       want.status, got.status, want.blk, got.blk, want.event_kind,
                       got.event_kind, want.role, got.role, want.size, got.size,
                       want.free_cnt, got.free_cnt, want.last, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) predict_command(in_tdata);
    end
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives file commands and disk sizes into the allocator with random gaps
// and receiver stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb
  import iba_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          stall_req = 0;
  bit          stall_busy = 0;

  always #10 clk = ~clk;

  inode_block_allocator_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  iba_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random gaps, plus long hold-offs on request
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_req > 0) begin
        stall_busy = 1;
        out_tready <= 1'b0;
        repeat (stall_req) @(negedge clk);
        stall_req = 0;
        stall_busy = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  // leaves the accepted transaction on the bus; the next step drops or replaces it
  task automatic send_cmd(logic [1:0] act, logic [3:0] fid, logic [12:0] alen,
                          bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, alen, fid, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_then_config(logic [8:0] size);
    in_tvalid <= 1'b0;
    while (pending > 0) @(negedge clk);
    repeat (600) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= size;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_cmd();
    int r;
    logic [12:0] alen;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: alen = 13'($urandom);
      1: alen = 13'd0;
      default: alen = 13'($urandom_range(0, 700));
    endcase
    if (r < 2) send_cmd(ACT_FORMAT, 4'($urandom), alen);
    else if (r < 25) send_cmd(ACT_LOAD, 4'($urandom), alen);
    else if (r < 42) send_cmd(ACT_DELETE, 4'($urandom), alen);
    else send_cmd(ACT_APPEND, 4'($urandom), alen);
  endtask

  initial begin
    logic [8:0] sizes [6];
    sizes = '{9'd256, 9'd1, 9'd40, 9'd511, 9'd0, 9'd300};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // before any format the free list is empty
    send_cmd(ACT_LOAD, 4'd0, 13'd0);
    send_cmd(ACT_DELETE, 4'd15, 13'd0);
    send_cmd(ACT_APPEND, 4'd3, 13'h1fff);
    send_cmd(ACT_FORMAT, 4'd0, 13'd0);
    send_cmd(ACT_LOAD, 4'd0, 13'd0);
    send_cmd(ACT_APPEND, 4'd0, 13'd0);
    send_cmd(ACT_APPEND, 4'd0, 13'd256);
    send_cmd(ACT_APPEND, 4'd0, 13'd1);
    send_cmd(ACT_APPEND, 4'd0, 13'h1fff);
    send_cmd(ACT_APPEND, 4'd0, 13'd7000);
    send_cmd(ACT_LOAD, 4'd15, 13'd0);
    send_cmd(ACT_APPEND, 4'd15, 13'd7680);
    send_cmd(ACT_LOAD, 4'd0, 13'd0);
    send_cmd(ACT_DELETE, 4'd15, 13'd0);
    send_cmd(ACT_DELETE, 4'd15, 13'd0);
    for (int p = 0; p < 6; p++) begin
      drain_then_config(sizes[p]);
      send_cmd(ACT_FORMAT, 4'($urandom), 13'($urandom));
      if (p == 1) begin
        send_cmd(ACT_LOAD, 4'd1, 13'd0);
        send_cmd(ACT_LOAD, 4'd2, 13'd0);
        send_cmd(ACT_APPEND, 4'd1, 13'd5);
      end
      if (p == 2) begin
        stall_req = 400;
        for (int i = 0; i < 8; i++) send_cmd(ACT_LOAD, i[3:0], 13'd0, 1);
        for (int i = 0; i < 8; i++) send_cmd(ACT_APPEND, i[3:0], 13'd600, 1);
        in_tvalid <= 1'b0;
        while (stall_busy || stall_req > 0) @(negedge clk);
      end
      for (int i = 0; i < 37; i++) begin
        random_cmd();
        if (i == 20 && p == 3) begin
          in_tvalid <= 1'b0;
          while (pending > 0) @(negedge clk);
        end
      end
    end
    in_tvalid <= 1'b0;
    while (pending > 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
